[rtl/pbdb_pkg.sv]
// shared constants, types and the base64 character table for the box downscaler
package pbdb_pkg;

  localparam int FRAME_WIDTH  = 800;
  localparam int FRAME_HEIGHT = 480;
  localparam int PALETTE_SIZE = 6;
  localparam int FIRST_CHROMA = 2;
  localparam int BLACK_INDEX  = 0;
  localparam int WHITE_INDEX  = 1;

  localparam int COL_W   = $clog2(FRAME_WIDTH);
  localparam int ROW_W   = $clog2(FRAME_HEIGHT);
  localparam int DIV_W   = (COL_W > ROW_W) ? COL_W : ROW_W;
  localparam int DIV_CNT_W = $clog2(DIV_W + 1);
  localparam int CNT_W   = 7;
  localparam int MEM_W   = PALETTE_SIZE * CNT_W;
  localparam int IDX_W   = 3;
  localparam int SCALE_W = 4;
  localparam int OFS_W   = 3;
  localparam int CHAR_W  = 7;
  localparam int LINE_W  = 7;
  localparam int SLOTS   = 6;
  localparam int SLOT_W  = $clog2(SLOTS + 1);

  localparam logic [CNT_W-1:0]   CNT_MAX     = 7'd127;
  localparam logic [SCALE_W-1:0] SCALE_RESET = 4'd3;
  localparam logic [SCALE_W-1:0] SCALE_MAX   = 4'd8;
  localparam logic [LINE_W-1:0]  LINE_LIMIT  = 7'd76;
  localparam logic [CHAR_W-1:0]  NEWLINE     = 7'd10;
  localparam logic [CHAR_W-1:0]  PAD_CHAR    = 7'd61;
  localparam logic [5:0]         SIX_MASK    = 6'd63;

  // whole boxes per row and per column, indexed by scale - 1
  localparam logic [COL_W:0] OUT_W_TAB [8] = '{
    (COL_W+1)'(FRAME_WIDTH / 1), (COL_W+1)'(FRAME_WIDTH / 2),
    (COL_W+1)'(FRAME_WIDTH / 3), (COL_W+1)'(FRAME_WIDTH / 4),
    (COL_W+1)'(FRAME_WIDTH / 5), (COL_W+1)'(FRAME_WIDTH / 6),
    (COL_W+1)'(FRAME_WIDTH / 7), (COL_W+1)'(FRAME_WIDTH / 8)};
  localparam logic [ROW_W:0] OUT_H_TAB [8] = '{
    (ROW_W+1)'(FRAME_HEIGHT / 1), (ROW_W+1)'(FRAME_HEIGHT / 2),
    (ROW_W+1)'(FRAME_HEIGHT / 3), (ROW_W+1)'(FRAME_HEIGHT / 4),
    (ROW_W+1)'(FRAME_HEIGHT / 5), (ROW_W+1)'(FRAME_HEIGHT / 6),
    (ROW_W+1)'(FRAME_HEIGHT / 7), (ROW_W+1)'(FRAME_HEIGHT / 8)};

  typedef struct packed {
    logic [COL_W-1:0] bx;
    logic             inbox;
    logic             first;
    logic             done;
    logic             fend;
  } pbdb_pos_t;

  typedef struct packed {
    logic             fs;
    logic             push;
    logic [IDX_W-1:0] idx;
    logic             fend;
  } pbdb_ev_t;

  typedef struct packed {
    logic              last;
    logic [CHAR_W-1:0] ch;
  } pbdb_char_t;

  function automatic logic [CHAR_W-1:0] b64_char(input logic [5:0] v);
    logic [CHAR_W-1:0] c;
    c = 7'd47;
    if (v < 6'd26) begin
      c = 7'd65 + CHAR_W'(v);
    end else if (v < 6'd52) begin
      c = 7'd97 + CHAR_W'(v - 6'd26);
    end else if (v < 6'd62) begin
      c = 7'd48 + CHAR_W'(v - 6'd52);
    end else if (v == 6'd62) begin
      c = 7'd43;
    end
    return c;
  endfunction

endpackage

[rtl/pbdb_pos.sv]
// scale register, pixel and box position tracking, resync divider after a scale write
module pbdb_pos (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [pbdb_pkg::SCALE_W-1:0]  cfg_data,
  input  logic                          acc,
  input  logic                          frame_start,
  output pbdb_pkg::pbdb_pos_t           pos_o,
  output logic                          busy_o
);

  logic [pbdb_pkg::SCALE_W-1:0]   scale_r;
  logic [pbdb_pkg::COL_W-1:0]     col_r, bx_r;
  logic [pbdb_pkg::ROW_W-1:0]     row_r, by_r;
  logic [pbdb_pkg::OFS_W-1:0]     dx_r, dy_r;
  logic                           div_busy_r;
  logic [pbdb_pkg::DIV_CNT_W-1:0] div_cnt_r;
  logic [pbdb_pkg::DIV_W-1:0]     col_dq_r, row_dq_r, col_dq_nxt, row_dq_nxt;
  logic [pbdb_pkg::OFS_W-1:0]     col_rem_r, row_rem_r, col_rem_nxt, row_rem_nxt;
  logic [pbdb_pkg::OFS_W:0]       col_sh, row_sh;
  logic                           col_ge, row_ge;

  logic [pbdb_pkg::SCALE_W-1:0]   s_eff;
  logic [pbdb_pkg::OFS_W-1:0]     s_m1;
  logic [pbdb_pkg::COL_W-1:0]     b_col, b_bx, col_nxt, bx_nxt;
  logic [pbdb_pkg::ROW_W-1:0]     b_row, b_by, row_nxt, by_nxt;
  logic [pbdb_pkg::OFS_W-1:0]     b_dx, b_dy, dx_nxt, dy_nxt;

  always_comb begin
    if (scale_r == '0) begin
      s_eff = 4'd1;
    end else if (scale_r > pbdb_pkg::SCALE_MAX) begin
      s_eff = pbdb_pkg::SCALE_MAX;
    end else begin
      s_eff = scale_r;
    end
    s_m1 = pbdb_pkg::OFS_W'(s_eff - 4'd1);

    // one quotient bit per cycle
    col_sh      = {col_rem_r, col_dq_r[pbdb_pkg::DIV_W-1]};
    col_ge      = col_sh >= s_eff;
    col_rem_nxt = col_ge ? pbdb_pkg::OFS_W'(col_sh - s_eff) : col_sh[pbdb_pkg::OFS_W-1:0];
    col_dq_nxt  = {col_dq_r[pbdb_pkg::DIV_W-2:0], col_ge};
    row_sh      = {row_rem_r, row_dq_r[pbdb_pkg::DIV_W-1]};
    row_ge      = row_sh >= s_eff;
    row_rem_nxt = row_ge ? pbdb_pkg::OFS_W'(row_sh - s_eff) : row_sh[pbdb_pkg::OFS_W-1:0];
    row_dq_nxt  = {row_dq_r[pbdb_pkg::DIV_W-2:0], row_ge};

    b_col = frame_start ? '0 : col_r;
    b_row = frame_start ? '0 : row_r;
    b_bx  = frame_start ? '0 : bx_r;
    b_by  = frame_start ? '0 : by_r;
    b_dx  = frame_start ? '0 : dx_r;
    b_dy  = frame_start ? '0 : dy_r;

    pos_o.bx    = b_bx;
    pos_o.inbox = ({1'b0, b_bx} < pbdb_pkg::OUT_W_TAB[s_m1]) &&
                  ({1'b0, b_by} < pbdb_pkg::OUT_H_TAB[s_m1]);
    pos_o.first = (b_dx == '0) && (b_dy == '0);
    pos_o.done  = (b_dx == s_m1) && (b_dy == s_m1);
    pos_o.fend  = (b_col == pbdb_pkg::COL_W'(pbdb_pkg::FRAME_WIDTH - 1)) &&
                  (b_row == pbdb_pkg::ROW_W'(pbdb_pkg::FRAME_HEIGHT - 1));

    col_nxt = b_col + 1'b1;
    bx_nxt  = b_bx;
    dx_nxt  = b_dx;
    row_nxt = b_row;
    by_nxt  = b_by;
    dy_nxt  = b_dy;
    if (pos_o.fend) begin
      col_nxt = '0;
      bx_nxt  = '0;
      dx_nxt  = '0;
      row_nxt = '0;
      by_nxt  = '0;
      dy_nxt  = '0;
    end else if (b_col == pbdb_pkg::COL_W'(pbdb_pkg::FRAME_WIDTH - 1)) begin
      col_nxt = '0;
      bx_nxt  = '0;
      dx_nxt  = '0;
      row_nxt = b_row + 1'b1;
      if (b_dy == s_m1) begin
        dy_nxt = '0;
        by_nxt = b_by + 1'b1;
      end else begin
        dy_nxt = b_dy + 1'b1;
      end
    end else if (b_dx == s_m1) begin
      dx_nxt = '0;
      bx_nxt = b_bx + 1'b1;
    end else begin
      dx_nxt = b_dx + 1'b1;
    end
  end

  assign busy_o = div_busy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scale_r    <= pbdb_pkg::SCALE_RESET;
      col_r      <= '0;
      row_r      <= '0;
      bx_r       <= '0;
      by_r       <= '0;
      dx_r       <= '0;
      dy_r       <= '0;
      div_busy_r <= 1'b0;
      div_cnt_r  <= '0;
      col_dq_r   <= '0;
      row_dq_r   <= '0;
      col_rem_r  <= '0;
      row_rem_r  <= '0;
    end else begin
      if (cfg_we) begin
        scale_r    <= cfg_data;
        div_busy_r <= 1'b1;
        div_cnt_r  <= pbdb_pkg::DIV_CNT_W'(pbdb_pkg::DIV_W);
        col_dq_r   <= pbdb_pkg::DIV_W'(col_r);
        row_dq_r   <= pbdb_pkg::DIV_W'(row_r);
        col_rem_r  <= '0;
        row_rem_r  <= '0;
      end else if (div_busy_r) begin
        col_dq_r  <= col_dq_nxt;
        row_dq_r  <= row_dq_nxt;
        col_rem_r <= col_rem_nxt;
        row_rem_r <= row_rem_nxt;
        div_cnt_r <= div_cnt_r - 1'b1;
        if (div_cnt_r == pbdb_pkg::DIV_CNT_W'(1)) begin
          div_busy_r <= 1'b0;
          bx_r       <= col_dq_nxt[pbdb_pkg::COL_W-1:0];
          dx_r       <= col_rem_nxt;
          by_r       <= row_dq_nxt[pbdb_pkg::ROW_W-1:0];
          dy_r       <= row_rem_nxt;
        end
      end
      if (acc) begin
        col_r <= col_nxt;
        row_r <= row_nxt;
        bx_r  <= bx_nxt;
        by_r  <= by_nxt;
        dx_r  <= dx_nxt;
        dy_r  <= dy_nxt;
      end
    end
  end

endmodule

[rtl/pbdb_count.sv]
// box count memory with read-modify-write, forwarding, clearing pass and box index pick
module pbdb_count (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 acc,
  input  pbdb_pkg::pbdb_pos_t  pos_i,
  input  logic [7:0]           pixel,
  input  logic                 frame_start,
  output logic                 s0_ready_o,
  output logic                 ev_valid_o,
  output pbdb_pkg::pbdb_ev_t   ev_o,
  input  logic                 ev_ready
);

  logic [pbdb_pkg::MEM_W-1:0] mem [pbdb_pkg::FRAME_WIDTH];
  logic [pbdb_pkg::MEM_W-1:0] rd_data_r;

  logic                       clr_r;
  logic [pbdb_pkg::COL_W-1:0] clr_addr_r;

  logic                       s1_v_r, s1_inbox_r, s1_first_r, s1_done_r, s1_fend_r, s1_fs_r;
  logic [pbdb_pkg::COL_W-1:0] s1_addr_r;
  logic [7:0]                 s1_pix_r;

  logic                       fwd_v_r;
  logic [pbdb_pkg::COL_W-1:0] fwd_addr_r;
  logic [pbdb_pkg::MEM_W-1:0] fwd_data_r;

  logic                       ev_v_r;
  pbdb_pkg::pbdb_ev_t         ev_r;

  logic                       adv1, we;
  logic [pbdb_pkg::COL_W-1:0] wa;
  logic [pbdb_pkg::MEM_W-1:0] wd, base, cnt_nxt;
  logic [pbdb_pkg::CNT_W-1:0] c;
  logic [pbdb_pkg::IDX_W-1:0] idx;

  function automatic logic [pbdb_pkg::IDX_W-1:0] pick(input logic [pbdb_pkg::MEM_W-1:0] cv);
    logic [pbdb_pkg::IDX_W-1:0] best;
    logic [pbdb_pkg::CNT_W-1:0] best_n;
    logic [pbdb_pkg::CNT_W-1:0] blk;
    best   = pbdb_pkg::IDX_W'(pbdb_pkg::WHITE_INDEX);
    best_n = '0;
    blk    = '0;
    for (int k = 0; k < pbdb_pkg::PALETTE_SIZE; k++) begin
      if (k == pbdb_pkg::BLACK_INDEX) blk = cv[k*pbdb_pkg::CNT_W +: pbdb_pkg::CNT_W];
    end
    for (int k = pbdb_pkg::FIRST_CHROMA; k < pbdb_pkg::PALETTE_SIZE; k++) begin
      if (cv[k*pbdb_pkg::CNT_W +: pbdb_pkg::CNT_W] > best_n) begin
        best   = pbdb_pkg::IDX_W'(k);
        best_n = cv[k*pbdb_pkg::CNT_W +: pbdb_pkg::CNT_W];
      end
    end
    if (best_n == '0) begin
      best = (blk != '0) ? pbdb_pkg::IDX_W'(pbdb_pkg::BLACK_INDEX)
                         : pbdb_pkg::IDX_W'(pbdb_pkg::WHITE_INDEX);
    end
    return best;
  endfunction

  always_comb begin
    adv1 = s1_v_r && (!ev_v_r || ev_ready);
    if (s1_first_r) begin
      base = '0;
    end else if (fwd_v_r && (fwd_addr_r == s1_addr_r)) begin
      base = fwd_data_r;
    end else begin
      base = rd_data_r;
    end
    cnt_nxt = base;
    for (int i = 0; i < pbdb_pkg::PALETTE_SIZE; i++) begin
      c = base[i*pbdb_pkg::CNT_W +: pbdb_pkg::CNT_W];
      if ((s1_pix_r == 8'(i)) && (c != pbdb_pkg::CNT_MAX)) begin
        cnt_nxt[i*pbdb_pkg::CNT_W +: pbdb_pkg::CNT_W] = c + 1'b1;
      end
    end
    idx = pick(cnt_nxt);
    we  = clr_r || (adv1 && s1_inbox_r);
    wa  = clr_r ? clr_addr_r : s1_addr_r;
    wd  = clr_r ? '0 : cnt_nxt;
  end

  assign s0_ready_o = !clr_r && (!s1_v_r || adv1);
  assign ev_valid_o = ev_v_r;
  assign ev_o       = ev_r;

  always_ff @(posedge clk) begin
    if (we) mem[wa] <= wd;
    if (acc) rd_data_r <= mem[pos_i.bx];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r      <= 1'b1;
      clr_addr_r <= '0;
      s1_v_r     <= 1'b0;
      fwd_v_r    <= 1'b0;
      ev_v_r     <= 1'b0;
    end else begin
      if (clr_r) begin
        if (clr_addr_r == pbdb_pkg::COL_W'(pbdb_pkg::FRAME_WIDTH - 1)) begin
          clr_r <= 1'b0;
        end else begin
          clr_addr_r <= clr_addr_r + 1'b1;
        end
      end
      if (acc) begin
        s1_v_r <= 1'b1;
      end else if (adv1) begin
        s1_v_r <= 1'b0;
      end
      if (we) fwd_v_r <= 1'b1;
      if (adv1) begin
        ev_v_r <= 1'b1;
      end else if (ev_ready) begin
        ev_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      s1_addr_r  <= pos_i.bx;
      s1_inbox_r <= pos_i.inbox;
      s1_first_r <= pos_i.first;
      s1_done_r  <= pos_i.done;
      s1_fend_r  <= pos_i.fend;
      s1_fs_r    <= frame_start;
      s1_pix_r   <= pixel;
    end
    if (we) begin
      fwd_addr_r <= wa;
      fwd_data_r <= wd;
    end
    if (adv1) begin
      ev_r.fs   <= s1_fs_r;
      ev_r.push <= s1_inbox_r && s1_done_r;
      ev_r.idx  <= idx;
      ev_r.fend <= s1_fend_r;
    end
  end

endmodule

[rtl/pbdb_pack.sv]
// index grouping, base64 characters, line breaks and the output register
module pbdb_pack (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              ev_valid,
  input  pbdb_pkg::pbdb_ev_t                ev,
  output logic                              ev_ready_o,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [pbdb_pkg::CHAR_W-1:0]       out_character,
  output logic                              out_last
);

  logic [pbdb_pkg::IDX_W-1:0]  pend0_r, pend1_r, pend0_nxt, pend1_nxt;
  logic [1:0]                  pcnt_r, pcnt_nxt;
  logic [pbdb_pkg::LINE_W-1:0] lc_r, lc_nxt;
  pbdb_pkg::pbdb_char_t        job_r [pbdb_pkg::SLOTS];
  pbdb_pkg::pbdb_char_t        slot [pbdb_pkg::SLOTS];
  logic [pbdb_pkg::SLOT_W-1:0] jcnt_r, nchars, cl;
  logic                        out_v_r;
  pbdb_pkg::pbdb_char_t        out_r;

  logic [1:0]                  pc, pc_a;
  logic [pbdb_pkg::LINE_W-1:0] lc, lc_add, lc_a;
  logic                        full, nl_a, pad, grp, take, head_mv;
  logic [pbdb_pkg::IDX_W-1:0]  p0_a, p1_a;
  logic [23:0]                 gword;
  logic [1:0]                  gused;

  always_comb begin
    pc     = ev.fs ? 2'd0 : pcnt_r;
    lc     = ev.fs ? '0 : lc_r;
    full   = ev.push && (pc == 2'd2);
    lc_add = lc + 7'd4;
    nl_a   = full && (lc_add >= pbdb_pkg::LINE_LIMIT);
    p0_a   = (ev.push && (pc == 2'd0)) ? ev.idx : pend0_r;
    p1_a   = (ev.push && (pc == 2'd1)) ? ev.idx : pend1_r;
    if (full) begin
      pc_a = 2'd0;
      lc_a = nl_a ? '0 : lc_add;
    end else begin
      pc_a = ev.push ? pc + 2'd1 : pc;
      lc_a = lc;
    end
    pad = ev.fend && (pc_a != 2'd0);
    grp = full || pad;
    if (full) begin
      gword = {5'd0, pend0_r, 5'd0, pend1_r, 5'd0, ev.idx};
      gused = 2'd3;
    end else begin
      gword = {5'd0, p0_a, 5'd0, ((pc_a == 2'd2) ? p1_a : 3'd0), 8'd0};
      gused = pc_a;
    end

    for (int i = 0; i < pbdb_pkg::SLOTS; i++) slot[i] = '0;
    if (grp) begin
      slot[0].ch = pbdb_pkg::b64_char(gword[23:18] & pbdb_pkg::SIX_MASK);
      slot[1].ch = pbdb_pkg::b64_char(gword[17:12] & pbdb_pkg::SIX_MASK);
      slot[2].ch = (gused >= 2'd2) ? pbdb_pkg::b64_char(gword[11:6]) : pbdb_pkg::PAD_CHAR;
      slot[3].ch = (gused == 2'd3) ? pbdb_pkg::b64_char(gword[5:0]) : pbdb_pkg::PAD_CHAR;
    end
    if (nl_a) slot[4].ch = pbdb_pkg::NEWLINE;
    cl = (grp ? pbdb_pkg::SLOT_W'(4) : '0) + (nl_a ? pbdb_pkg::SLOT_W'(1) : '0);
    if (ev.fend) begin
      for (int i = 0; i < pbdb_pkg::SLOTS; i++) begin
        if (pbdb_pkg::SLOT_W'(i) == cl) begin
          slot[i].ch   = pbdb_pkg::NEWLINE;
          slot[i].last = 1'b1;
        end
      end
    end
    nchars = cl + (ev.fend ? pbdb_pkg::SLOT_W'(1) : '0);

    ev_ready_o = (jcnt_r == '0) || (nchars == '0);
    take       = ev_valid && ev_ready_o;
    head_mv    = (jcnt_r != '0) && (!out_v_r || !out_stall);

    pend0_nxt = pend0_r;
    pend1_nxt = pend1_r;
    pcnt_nxt  = pcnt_r;
    lc_nxt    = lc_r;
    if (take) begin
      pend0_nxt = p0_a;
      pend1_nxt = p1_a;
      pcnt_nxt  = ev.fend ? 2'd0 : pc_a;
      lc_nxt    = ev.fend ? '0 : lc_a;
    end
  end

  assign out_valid     = out_v_r;
  assign out_character = out_r.ch;
  assign out_last      = out_r.last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pcnt_r  <= '0;
      lc_r    <= '0;
      jcnt_r  <= '0;
      out_v_r <= 1'b0;
    end else begin
      pcnt_r <= pcnt_nxt;
      lc_r   <= lc_nxt;
      if (take && (nchars != '0)) begin
        jcnt_r <= nchars;
      end else if (head_mv) begin
        jcnt_r <= jcnt_r - 1'b1;
      end
      if (head_mv) begin
        out_v_r <= 1'b1;
      end else if (!out_stall) begin
        out_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    pend0_r <= pend0_nxt;
    pend1_r <= pend1_nxt;
    if (take && (nchars != '0)) begin
      for (int i = 0; i < pbdb_pkg::SLOTS; i++) job_r[i] <= slot[i];
    end else if (head_mv) begin
      for (int i = 0; i < pbdb_pkg::SLOTS - 1; i++) job_r[i] <= job_r[i+1];
      job_r[pbdb_pkg::SLOTS-1] <= '0;
    end
    if (head_mv) out_r <= job_r[0];
  end

endmodule

[rtl/palette_box_downscale_base64_unit.sv]
// top level: palette box downscaler with base64 text output
// path: a pixel's first character passes the stage-1, event, job-slot and output registers
// throughput: one pixel per cycle while no characters wait; a pixel that closes a group waits
//   until the previous group's 4 to 6 characters have moved out
// reset: synchronous; input stalls for the count clearing pass and the resync after each scale write
module palette_box_downscale_base64_unit (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [pbdb_pkg::SCALE_W-1:0]     cfg_data,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [7:0]                       in_pixel,
  input  logic                             in_frame_start,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [pbdb_pkg::CHAR_W-1:0]      out_character,
  output logic                             out_last
);

  pbdb_pkg::pbdb_pos_t pos;
  pbdb_pkg::pbdb_ev_t  ev;
  logic                pos_busy, s0_ready, ev_valid, ev_ready, acc;

  assign in_stall = !s0_ready || pos_busy;
  assign acc      = in_valid && !in_stall;

  pbdb_pos u_pos (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_we      (cfg_we),
    .cfg_data    (cfg_data),
    .acc         (acc),
    .frame_start (in_frame_start),
    .pos_o       (pos),
    .busy_o      (pos_busy)
  );

  pbdb_count u_count (
    .clk         (clk),
    .rst_n       (rst_n),
    .acc         (acc),
    .pos_i       (pos),
    .pixel       (in_pixel),
    .frame_start (in_frame_start),
    .s0_ready_o  (s0_ready),
    .ev_valid_o  (ev_valid),
    .ev_o        (ev),
    .ev_ready    (ev_ready)
  );

  pbdb_pack u_pack (
    .clk           (clk),
    .rst_n         (rst_n),
    .ev_valid      (ev_valid),
    .ev            (ev),
    .ev_ready_o    (ev_ready),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_character (out_character),
    .out_last      (out_last)
  );

endmodule

[rtl/pbdb_chk.sv]
// port-level checker for the box downscaler, bound to the top level
module pbdb_chk (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        cfg_we,
  input logic                        in_stall,
  input logic                        out_valid,
  input logic                        out_stall,
  input logic [pbdb_pkg::CHAR_W-1:0] out_character,
  input logic                        out_last
);

  // stalled output beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_character) && $stable(out_last))
    else $error("output beat changed while stalled");

  a_last_nl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last |-> out_character == pbdb_pkg::NEWLINE)
    else $error("frame close is not a newline");

  // clearing pass blocks input and output is empty after reset
  a_reset: assert property (@(posedge clk)
    !rst_n |=> in_stall && !out_valid)
    else $error("not quiet after reset");

  // position resync blocks input after a scale write
  a_cfg: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_we |=> in_stall)
    else $error("input open during position resync");

endmodule

bind palette_box_downscale_base64_unit pbdb_chk u_chk (
  .clk           (clk),
  .rst_n         (rst_n),
  .cfg_we        (cfg_we),
  .in_stall      (in_stall),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .out_character (out_character),
  .out_last      (out_last)
);
